FILE: src/baps_pkg.sv
// Package: shared constants, codes and types of the buzzer alert pattern sequencer.
`default_nettype none

package baps_pkg;

    localparam int TIME_BITS_DEF = 24;
    localparam int PT_W          = 18;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MS         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_MS          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD_MV = 3'd4;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    localparam logic [1:0] KEY_IDLE       = 2'd0;
    localparam logic [1:0] KEY_POWER_DOWN = 2'd1;
    localparam logic [1:0] KEY_POWER_UP   = 2'd2;

    localparam logic [PT_W-1:0] LONG_BEEP_EXTRA_MS = 18'd160;

    localparam logic [9:0]  TICK_MS_RST          = 10'd40;
    localparam logic [13:0] SHORT_MS_RST         = 14'd40;
    localparam logic [15:0] LONG_MS_RST          = 16'd1000;
    localparam logic [15:0] WARN_MS_RST          = 16'd200;
    localparam logic [15:0] LOW_THRESHOLD_MV_RST = 16'd10400;

    typedef struct packed {
        logic [9:0]  tick_ms;
        logic [13:0] short_ms;
        logic [15:0] long_ms;
        logic [15:0] warn_ms;
        logic [15:0] low_threshold_mv;
    } cfg_t;

    typedef struct packed {
        logic       prev_ok;
        logic       stable_ok;
        logic [1:0] key_mode;
        logic       ringing;
    } flags_t;

endpackage

`default_nettype wire

FILE: src/baps_step.sv
// Next-state logic for one tick or key beat of the buzzer alert pattern sequencer.
`default_nettype none

module baps_step #(
    parameter int TIME_BITS = baps_pkg::TIME_BITS_DEF
) (
    input  baps_pkg::cfg_t         cfg,
    input  baps_pkg::flags_t       flags_cur,
    input  logic [TIME_BITS-1:0]   elapsed_cur,
    input  logic [TIME_BITS-1:0]   low_accum_cur,
    input  logic                   op,
    input  logic [15:0]            battery_mv,
    input  logic [1:0]             key_code,
    output baps_pkg::flags_t       flags_new,
    output logic [TIME_BITS-1:0]   elapsed_new,
    output logic [TIME_BITS-1:0]   low_accum_new
);
    import baps_pkg::*;

    function automatic logic [TIME_BITS-1:0] sat_add(
        input logic [TIME_BITS-1:0] a,
        input logic [9:0]           b
    );
        logic [TIME_BITS:0] s;
        s = (TIME_BITS+1)'(a) + (TIME_BITS+1)'(b);
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

    function automatic logic hit(
        input logic [TIME_BITS-1:0] t,
        input logic [PT_W-1:0]      p
    );
        return t == TIME_BITS'(p);
    endfunction

    logic [PT_W-1:0] ti, s1, s2, s4;
    logic [PT_W-1:0] p0, p1, p2, p3, p4, p5, p_bat_end, p_down_end, p_up_end;

    assign ti         = PT_W'(cfg.tick_ms);
    assign s1         = PT_W'(cfg.short_ms);
    assign s2         = s1 << 1;
    assign s4         = s1 << 2;
    assign p0         = ti;
    assign p1         = s1 + ti;
    assign p2         = s2 + ti;
    assign p3         = s2 + s1 + ti;
    assign p4         = s4 + ti;
    assign p5         = s4 + s1 + ti;
    assign p_bat_end  = p5 + PT_W'(cfg.long_ms);
    assign p_down_end = p1 + LONG_BEEP_EXTRA_MS;
    assign p_up_end   = p3 + PT_W'(cfg.long_ms);

    always_comb begin
        logic                 ok;
        logic                 change;
        logic [TIME_BITS-1:0] el;
        logic [TIME_BITS-1:0] acc;
        flags_t               f;

        f   = flags_cur;
        el  = elapsed_cur;
        acc = low_accum_cur;
        ok  = battery_mv >= cfg.low_threshold_mv;
        change = ok != flags_cur.prev_ok;

        if (op == OP_KEY) begin
            if (f.stable_ok) begin
                f.ringing  = 1'b0;
                f.key_mode = key_code;
                el         = '0;
            end
        end else begin
            if (change) begin
                acc = '0;
                if (!ok) begin
                    el = '0;
                end else begin
                    f.ringing   = 1'b0;
                    f.stable_ok = 1'b1;
                end
            end
            f.prev_ok = ok;
            if (!ok) begin
                acc = sat_add(acc, cfg.tick_ms);
            end
            if (acc == TIME_BITS'(cfg.warn_ms)) begin
                el          = '0;
                f.stable_ok = 1'b0;
            end
            el = sat_add(el, cfg.tick_ms);

            if (!f.stable_ok) begin
                if (hit(el, p0)) f.ringing = 1'b1;
                else if (hit(el, p1)) f.ringing = 1'b0;
                else if (hit(el, p2)) f.ringing = 1'b1;
                else if (hit(el, p3)) f.ringing = 1'b0;
                else if (hit(el, p4)) f.ringing = 1'b1;
                else if (hit(el, p5)) f.ringing = 1'b0;
                else if (hit(el, p_bat_end)) begin
                    f.ringing = 1'b0;
                    el        = '0;
                end
            end else begin
                case (f.key_mode)
                    KEY_POWER_DOWN: begin
                        if (hit(el, p0)) f.ringing = 1'b1;
                        else if (hit(el, p_down_end)) begin
                            f.ringing  = 1'b0;
                            f.key_mode = KEY_IDLE;
                        end
                    end
                    KEY_POWER_UP: begin
                        if (hit(el, p0)) f.ringing = 1'b1;
                        else if (hit(el, p1)) f.ringing = 1'b0;
                        else if (hit(el, p2)) f.ringing = 1'b1;
                        else if (hit(el, p3)) f.ringing = 1'b0;
                        else if (hit(el, p_up_end)) begin
                            f.ringing  = 1'b0;
                            f.key_mode = KEY_IDLE;
                        end
                    end
                    default: begin
                        f.ringing = f.ringing;
                    end
                endcase
            end
        end

        flags_new     = f;
        elapsed_new   = el;
        low_accum_new = acc;
    end

endmodule

`default_nettype wire

FILE: src/buzzer_alert_pattern_sequencer_unit.sv
// Top level of the buzzer alert pattern sequencer: handshake, registers and state.
//
// Input channel s_*: each beat is a tick (s_op low) carrying a battery sample in
// millivolts, or a key event (s_op high) carrying s_key_code. Every input beat
// yields exactly one result beat on m_*: the buzzer level and the stable-low flag.
// Configuration: cfg_wr_en, cfg_addr and cfg_wdata write one register per cycle;
// write only while no beat is in flight. Indexes beyond the list are ignored.
// A beat in the input register is processed into the output register when
// that is empty or m_ready is high. Throughput: one beat per cycle while m_ready
// holds, set by a single input register feeding one step of next-state logic
// into the output register. A held result does not block s_ready while the
// input register is empty; when the receiver stalls with both registers full,
// s_ready drops until m_ready returns. Reset clears all state to its idle values
// and loads the default register values; no beat is lost or repeated.
`default_nettype none

module buzzer_alert_pattern_sequencer_unit #(
    parameter int TIME_BITS = baps_pkg::TIME_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [15:0]                       s_battery_mv,
    input  logic [1:0]                        s_key_code,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_buzzer_on,
    output logic                              m_battery_low,
    input  logic                              cfg_wr_en,
    input  logic [baps_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [baps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import baps_pkg::*;

    cfg_t                 cfg_reg;
    flags_t               flags_reg, flags_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0] low_accum_reg, low_accum_next;

    logic        in_valid_reg;
    logic        in_op_reg;
    logic [15:0] in_mv_reg;
    logic [1:0]  in_key_reg;
    logic        out_valid_reg;
    logic        out_buzzer_reg;
    logic        out_low_reg;
    logic        fire;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid       = out_valid_reg;
    assign m_buzzer_on   = out_buzzer_reg;
    assign m_battery_low = out_low_reg;

    baps_step #(
        .TIME_BITS(TIME_BITS)
    ) u_step (
        .cfg          (cfg_reg),
        .flags_cur    (flags_reg),
        .elapsed_cur  (elapsed_reg),
        .low_accum_cur(low_accum_reg),
        .op           (in_op_reg),
        .battery_mv   (in_mv_reg),
        .key_code     (in_key_reg),
        .flags_new    (flags_next),
        .elapsed_new  (elapsed_next),
        .low_accum_new(low_accum_next)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tick_ms          <= TICK_MS_RST;
            cfg_reg.short_ms         <= SHORT_MS_RST;
            cfg_reg.long_ms          <= LONG_MS_RST;
            cfg_reg.warn_ms          <= WARN_MS_RST;
            cfg_reg.low_threshold_mv <= LOW_THRESHOLD_MV_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_TICK_MS:          cfg_reg.tick_ms          <= cfg_wdata[9:0];
                CFG_SHORT_MS:         cfg_reg.short_ms         <= cfg_wdata[13:0];
                CFG_LONG_MS:          cfg_reg.long_ms          <= cfg_wdata;
                CFG_WARN_MS:          cfg_reg.warn_ms          <= cfg_wdata;
                CFG_LOW_THRESHOLD_MV: cfg_reg.low_threshold_mv <= cfg_wdata;
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_op_reg  <= s_op;
            in_mv_reg  <= s_battery_mv;
            in_key_reg <= s_key_code;
        end
    end

    // block state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg.prev_ok   <= 1'b1;
            flags_reg.stable_ok <= 1'b1;
            flags_reg.key_mode  <= KEY_IDLE;
            flags_reg.ringing   <= 1'b0;
            elapsed_reg         <= '0;
            low_accum_reg       <= '0;
            out_valid_reg       <= 1'b0;
        end else begin
            if (fire) begin
                flags_reg     <= flags_next;
                elapsed_reg   <= elapsed_next;
                low_accum_reg <= low_accum_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_buzzer_reg <= flags_next.ringing;
            out_low_reg    <= !flags_next.stable_ok;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_buzzer_alarm_checker.sv
// Checker for the buzzer alert sequencer: predicts each result beat and compares.
`timescale 1ns / 1ps

module tb_buzzer_alarm_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_op,
    input  logic [15:0]                     s_battery_mv,
    input  logic [1:0]                      s_key_code,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_buzzer_on,
    input  logic                            m_battery_low,
    input  logic                            cfg_wr_en,
    input  logic [baps_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [baps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int unsigned                     alarm_pending,
    output int unsigned                     mismatch_cnt,
    output int unsigned                     checked_cnt
);
    import baps_pkg::*;

    localparam longint unsigned CLOCK_MAX = (64'd1 << TIME_BITS_DEF) - 1;

    typedef struct packed {
        logic buzzer_on;
        logic battery_low;
    } alarm_t;

    cfg_t            regs;
    logic            batt_ok_prev;
    logic            batt_stable_ok;
    logic            ringing;
    logic [1:0]      key_mode;
    longint unsigned elapsed_ms;
    longint unsigned low_ms;
    alarm_t          alarm_expect_q[$];

    function automatic longint unsigned clamp_add(longint unsigned a, longint unsigned b);
        longint unsigned sum;
        sum = a + b;
        return (sum > CLOCK_MAX) ? CLOCK_MAX : sum;
    endfunction

    function automatic void advance_pattern();
        longint unsigned t;
        longint unsigned i;
        longint unsigned s;
        longint unsigned l;
        t = elapsed_ms;
        i = regs.tick_ms;
        s = regs.short_ms;
        l = regs.long_ms;
        if (!batt_stable_ok) begin
            if (t == i) ringing = 1'b1;
            else if (t == s + i) ringing = 1'b0;
            else if (t == 2 * s + i) ringing = 1'b1;
            else if (t == 3 * s + i) ringing = 1'b0;
            else if (t == 4 * s + i) ringing = 1'b1;
            else if (t == 5 * s + i) ringing = 1'b0;
            else if (t == 5 * s + i + l) begin
                ringing    = 1'b0;
                elapsed_ms = 0;
            end
        end else if (key_mode == KEY_POWER_DOWN) begin
            if (t == i) ringing = 1'b1;
            else if (t == s + i + LONG_BEEP_EXTRA_MS) begin
                ringing  = 1'b0;
                key_mode = KEY_IDLE;
            end
        end else if (key_mode == KEY_POWER_UP) begin
            if (t == i) ringing = 1'b1;
            else if (t == s + i) ringing = 1'b0;
            else if (t == 2 * s + i) ringing = 1'b1;
            else if (t == 3 * s + i) ringing = 1'b0;
            else if (t == 3 * s + i + l) begin
                ringing  = 1'b0;
                key_mode = KEY_IDLE;
            end
        end
    endfunction

    function automatic alarm_t step_alarm(logic op, logic [15:0] mv, logic [1:0] key);
        logic   ok;
        alarm_t res;
        if (op == OP_KEY) begin
            if (batt_stable_ok) begin
                ringing    = 1'b0;
                key_mode   = key;
                elapsed_ms = 0;
            end
        end else begin
            ok = (mv >= regs.low_threshold_mv);
            if (ok != batt_ok_prev) begin
                if (!ok) begin
                    elapsed_ms = 0;
                    low_ms     = 0;
                end else begin
                    ringing        = 1'b0;
                    low_ms         = 0;
                    batt_stable_ok = 1'b1;
                end
            end
            batt_ok_prev = ok;
            if (!ok) low_ms = clamp_add(low_ms, regs.tick_ms);
            if (low_ms == regs.warn_ms) begin
                elapsed_ms     = 0;
                batt_stable_ok = 1'b0;
            end
            elapsed_ms = clamp_add(elapsed_ms, regs.tick_ms);
            advance_pattern();
        end
        res.buzzer_on   = ringing;
        res.battery_low = !batt_stable_ok;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        alarm_t want;
        alarm_t got;
        if (!aresetn) begin
            regs = '{tick_ms: TICK_MS_RST, short_ms: SHORT_MS_RST, long_ms: LONG_MS_RST,
                     warn_ms: WARN_MS_RST, low_threshold_mv: LOW_THRESHOLD_MV_RST};
            batt_ok_prev   = 1'b1;
            batt_stable_ok = 1'b1;
            ringing        = 1'b0;
            key_mode       = KEY_IDLE;
            elapsed_ms     = 0;
            low_ms         = 0;
            alarm_expect_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_TICK_MS:          regs.tick_ms          = cfg_wdata[9:0];
                    CFG_SHORT_MS:         regs.short_ms         = cfg_wdata[13:0];
                    CFG_LONG_MS:          regs.long_ms          = cfg_wdata;
                    CFG_WARN_MS:          regs.warn_ms          = cfg_wdata;
                    CFG_LOW_THRESHOLD_MV: regs.low_threshold_mv = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got.buzzer_on   = m_buzzer_on;
                got.battery_low = m_battery_low;
                if (alarm_expect_q.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("%0t unexpected result beat: buzzer_on %0b battery_low %0b",
                                 $time, got.buzzer_on, got.battery_low);
                    mismatch_cnt <= mismatch_cnt + 1;
                end else begin
                    want = alarm_expect_q.pop_front();
                    checked_cnt <= checked_cnt + 1;
                    if (got.buzzer_on !== want.buzzer_on ||
                        got.battery_low !== want.battery_low) begin
                        if (mismatch_cnt < 10)
                            $display("%0t mismatch: buzzer_on exp %0b got %0b, %s %0b got %0b",
                                     $time, want.buzzer_on, got.buzzer_on, "battery_low exp",
                                     want.battery_low, got.battery_low);
                        mismatch_cnt <= mismatch_cnt + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                alarm_expect_q.push_back(step_alarm(s_op, s_battery_mv, s_key_code));
        end
        alarm_pending <= alarm_expect_q.size();
    end

endmodule

FILE: tb/tb_buzzer_alert_pattern_sequencer_unit.sv
// Testbench top for the buzzer alert sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_buzzer_alert_pattern_sequencer_unit;
    import baps_pkg::*;

    localparam int                    LIMIT_CYCLES = 500_000;
    localparam int                    SOAK_BEATS   = 200;
    localparam int                    PHASE_BEATS  = 60;
    localparam int                    PHASES       = 10;
    localparam logic [1:0]            KEY_RESERVED = 2'd3;
    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE    = 3'd7;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_op         = OP_TICK;
    logic [15:0]           s_battery_mv = '0;
    logic [1:0]            s_key_code   = KEY_IDLE;
    logic                  m_ready      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  s_ready;
    logic                  m_valid;
    logic                  m_buzzer_on;
    logic                  m_battery_low;

    int unsigned alarm_pending;
    int unsigned mismatch_cnt;
    int unsigned checked_cnt;
    int unsigned beats_sent   = 0;
    int unsigned settings_cnt = 0;
    int unsigned cycle_cnt    = 0;
    int          gap_pct      = 0;
    int          stall_pct    = 0;
    int          stall_left   = 0;
    logic [15:0] thr_now      = LOW_THRESHOLD_MV_RST;

    always #5 aclk = ~aclk;

    buzzer_alert_pattern_sequencer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_battery_mv  (s_battery_mv),
        .s_key_code    (s_key_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_buzzer_on   (m_buzzer_on),
        .m_battery_low (m_battery_low),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    tb_buzzer_alarm_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_battery_mv  (s_battery_mv),
        .s_key_code    (s_key_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_buzzer_on   (m_buzzer_on),
        .m_battery_low (m_battery_low),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .alarm_pending (alarm_pending),
        .mismatch_cnt  (mismatch_cnt),
        .checked_cnt   (checked_cnt)
    );

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (stall_pct > 0 && $urandom_range(99, 0) < stall_pct) begin
            stall_left <= $urandom_range(18, 0);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic push_beat(logic op, logic [15:0] mv, logic [1:0] key);
        if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_battery_mv <= mv;
        s_key_code   <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic push_tick(logic low);
        logic [15:0] mv;
        if (low && thr_now != 0) begin
            case ($urandom_range(7, 0))
                0: mv = thr_now - 16'd1;
                1: mv = '0;
                default: mv = 16'($urandom_range(thr_now - 16'd1, 0));
            endcase
        end else begin
            case ($urandom_range(7, 0))
                0: mv = thr_now;
                1: mv = 16'hFFFF;
                default: mv = 16'($urandom_range(65535, thr_now));
            endcase
        end
        push_beat(OP_TICK, mv, 2'($urandom));
    endtask

    function automatic logic [1:0] pick_key();
        if ($urandom_range(9, 0) < 7)
            return $urandom_range(1, 0) ? KEY_POWER_UP : KEY_POWER_DOWN;
        return 2'($urandom);
    endfunction

    // hold off until every result beat is back, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (alarm_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_regs(logic [15:0] t, logic [15:0] sh, logic [15:0] lg,
                             logic [15:0] wn, logic [15:0] th);
        logic [CFG_IDX_W-1:0] idx[6];
        logic [15:0]          val[6];
        drain();
        idx = '{CFG_TICK_MS, CFG_SHORT_MS, CFG_LONG_MS, CFG_WARN_MS,
                CFG_LOW_THRESHOLD_MV, CFG_SPARE};
        val = '{t, sh, lg, wn, th, 16'($urandom)};
        for (int k = 0; k < 6; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx[k];
            cfg_wdata <= val[k];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        thr_now = th;
        settings_cnt++;
    endtask

    task automatic run_phase(int unsigned beats);
        int unsigned target;
        int          n;
        target = beats_sent + beats;
        while (beats_sent < target) begin
            n = $urandom_range(40, 1);
            case ($urandom_range(9, 0))
                0, 1, 2: begin
                    repeat (n) push_tick(1'b0);
                end
                3, 4: begin
                    push_beat(OP_KEY, 16'($urandom), pick_key());
                    repeat (n) push_tick(1'b0);
                end
                5, 6: begin
                    repeat (n + 5) begin
                        if ($urandom_range(9, 0) == 0)
                            push_beat(OP_KEY, 16'($urandom), pick_key());
                        else
                            push_tick(1'b1);
                    end
                end
                7: begin
                    repeat (n % 6 + 1) push_beat(1'($urandom), 16'($urandom), 2'($urandom));
                end
                8: begin
                    repeat (n % 8 + 1) push_tick(1'($urandom));
                end
                default: begin
                    if ($urandom_range(3, 0) == 0) drain();
                end
            endcase
        end
    endtask

    initial begin : stimulus
        logic [15:0] t;
        logic [15:0] sh;
        logic [15:0] lg;
        logic [15:0] wn;
        logic [15:0] th;
        int          pct_pick[4];
        pct_pick = '{5, 15, 30, 50};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_beat(OP_TICK, 16'hFFFF, KEY_IDLE);
        push_beat(OP_TICK, LOW_THRESHOLD_MV_RST, KEY_IDLE);
        push_beat(OP_KEY, 16'h0000, KEY_POWER_UP);
        push_beat(OP_TICK, LOW_THRESHOLD_MV_RST - 16'd1, KEY_IDLE);
        push_beat(OP_TICK, 16'h0000, KEY_POWER_DOWN);
        push_beat(OP_KEY, 16'hFFFF, KEY_RESERVED);
        push_beat(OP_TICK, 16'hFFFF, KEY_IDLE);
        push_beat(OP_KEY, 16'h0000, KEY_IDLE);
        push_beat(OP_KEY, 16'h0000, KEY_POWER_DOWN);
        push_beat(OP_TICK, 16'hFFFF, KEY_RESERVED);

        // zero tick and zero warn, threshold at the bottom
        load_regs(16'd0, 16'd1, 16'd1, 16'd0, 16'd0);
        push_beat(OP_TICK, 16'h0000, KEY_IDLE);
        push_beat(OP_KEY, 16'h0000, KEY_POWER_UP);
        push_beat(OP_TICK, 16'hFFFF, KEY_IDLE);
        push_beat(OP_TICK, 16'h0001, KEY_IDLE);

        // all ones: fields wider than their register get masked
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_beat(OP_TICK, 16'hFFFF, KEY_IDLE);
        push_beat(OP_TICK, 16'hFFFE, KEY_IDLE);
        push_beat(OP_KEY, 16'h0000, KEY_POWER_DOWN);
        push_beat(OP_TICK, 16'hFFFF, KEY_IDLE);
        push_beat(OP_KEY, 16'h0000, KEY_POWER_UP);
        push_beat(OP_TICK, 16'hFFFF, KEY_IDLE);

        // long low stretch at the widest tick and a warn of 60000 ms
        load_regs(16'd1023, 16'd10000, 16'd60000, 16'd60000, 16'hFFFF);
        repeat (SOAK_BEATS) push_beat(OP_TICK, 16'($urandom_range(65534, 0)), KEY_IDLE);
        push_beat(OP_KEY, 16'h0000, KEY_POWER_DOWN);
        push_beat(OP_TICK, 16'hFFFF, KEY_IDLE);
        push_beat(OP_KEY, 16'h0000, KEY_POWER_UP);
        push_beat(OP_TICK, 16'hFFFF, KEY_IDLE);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    t  = 16'd1;
                    sh = 16'd1;
                    lg = 16'd1;
                    wn = 16'd1;
                    th = 16'($urandom_range(60000, 1000));
                end
                1: begin
                    t  = 16'd1023;
                    sh = 16'd10000;
                    lg = 16'd60000;
                    wn = 16'd60000;
                    th = 16'hFFFF;
                end
                default: begin
                    t  = 16'($urandom_range(200, 1));
                    sh = ($urandom_range(4, 0) != 0) ? 16'(t * $urandom_range(4, 1))
                                                     : 16'($urandom_range(10000, 1));
                    lg = ($urandom_range(4, 0) != 0) ? 16'(t * $urandom_range(10, 1))
                                                     : 16'($urandom_range(60000, 1));
                    wn = ($urandom_range(4, 0) != 0) ? 16'(t * $urandom_range(6, 1))
                                                     : 16'($urandom_range(60000, 1));
                    th = 16'($urandom_range(60000, 1000));
                    if ($urandom_range(3, 0) == 0) begin
                        t[15:10]  = 6'($urandom);
                        sh[15:14] = 2'($urandom);
                    end
                end
            endcase
            load_regs(t, sh, lg, wn, th);
            if (p == 0 || p == PHASES - 1) begin
                gap_pct = 0;
                stall_pct <= 0;
            end else begin
                gap_pct = pct_pick[$urandom_range(3, 0)];
                stall_pct <= pct_pick[$urandom_range(3, 0)];
            end
            run_phase(PHASE_BEATS);
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("covered %0d beats, %0d results compared, over %0d register settings",
                 beats_sent, checked_cnt, settings_cnt);
        $display("with a long low stretch, zero tick and warn, masked writes, key code three");
        if (mismatch_cnt == 0 && alarm_pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/baps_pkg.sv
src/baps_step.sv
src/buzzer_alert_pattern_sequencer_unit.sv
tb/tb_buzzer_alarm_checker.sv
tb/tb_buzzer_alert_pattern_sequencer_unit.sv
